// File: sv/dto_pkg.sv
package dto_pkg;

	localparam int MAX_NODES   = 32;
	localparam int MAX_OUTPUTS = 32;
	localparam int DEPTH       = MAX_NODES * MAX_OUTPUTS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int IDX_W       = $clog2(MAX_NODES);
	localparam int NODE_W      = 5;
	localparam int SLOT_W      = 5;
	localparam int CNT_W       = 6;
	localparam int REM_W       = 11;
	localparam int EDGE_W      = 6;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BAD_ENTRY    = 2'd1;
	localparam logic [1:0] ST_EXTRA_SOURCE = 2'd2;
	localparam logic [1:0] ST_UNREACHED    = 2'd3;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_ENTRY_NODE = 2'd1;

	typedef struct packed {
		logic [NODE_W-1:0] node_index;
		logic [SLOT_W-1:0] slot_index;
		logic [NODE_W-1:0] target;
		logic              target_valid;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] position;
		logic [NODE_W-1:0] node_id;
		logic [1:0]        status;
		logic              last_result;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       run_init;
		logic       tally_issue;
		logic       sel_entry;
		logic       sweep_init;
		logic       sweep_step;
		logic       walk_init;
		logic       walk_rd;
		logic       walk_ex;
		logic       emit_step;
		logic       emit_err;
		logic [1:0] err_code;
		logic       clear_step;
	} cmd_t;

	typedef struct packed {
		logic entry_bad;
		logic tally_done;
		logic rem_nz;
		logic sweep_last;
		logic sw_is_entry;
		logic sp_zero;
		logic clear_last;
	} sts_t;

endpackage

// File: sv/dto_ctrl.sv
module dto_ctrl import dto_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_TALLY = 4'd2;
	localparam logic [3:0] S_CHKE  = 4'd3;
	localparam logic [3:0] S_CHKS  = 4'd4;
	localparam logic [3:0] S_WRD   = 4'd5;
	localparam logic [3:0] S_WEX   = 4'd6;
	localparam logic [3:0] S_CHKA  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_ERR   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] err_q, err_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		err_d   = err_q;
		cmd.err_code = err_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last) begin
						cmd.run_init = 1'b1;
						if (sts.entry_bad) begin
							err_d   = ST_BAD_ENTRY;
							state_d = S_ERR;
						end else begin
							state_d = S_TALLY;
						end
					end
				end
			end
			S_TALLY: begin
				cmd.tally_issue = !sts.tally_done;
				if (sts.tally_done)
					state_d = S_CHKE;
			end
			S_CHKE: begin
				cmd.sel_entry = 1'b1;
				if (sts.rem_nz) begin
					err_d   = ST_BAD_ENTRY;
					state_d = S_ERR;
				end else begin
					cmd.sweep_init = 1'b1;
					state_d = S_CHKS;
				end
			end
			S_CHKS: begin
				cmd.sweep_step = 1'b1;
				if (!sts.rem_nz && !sts.sw_is_entry) begin
					err_d   = ST_EXTRA_SOURCE;
					state_d = S_ERR;
				end else if (sts.sweep_last) begin
					cmd.walk_init = 1'b1;
					state_d = S_WRD;
				end
			end
			S_WRD: begin
				if (sts.sp_zero) begin
					cmd.sweep_init = 1'b1;
					state_d = S_CHKA;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d = S_WEX;
				end
			end
			S_WEX: begin
				cmd.walk_ex = 1'b1;
				state_d = S_WRD;
			end
			S_CHKA: begin
				cmd.sweep_step = 1'b1;
				if (sts.rem_nz) begin
					err_d   = ST_UNREACHED;
					state_d = S_ERR;
				end else if (sts.sweep_last) begin
					cmd.sweep_init = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.sweep_last)
					state_d = S_CLEAR;
			end
			S_ERR: begin
				cmd.emit_err = 1'b1;
				state_d = S_CLEAR;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

endmodule

// File: sv/dto_dp.sv
module dto_dp import dto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  in_item_t          item,
	input  logic [CNT_W-1:0]  n,
	input  logic [NODE_W-1:0] entry,
	output sts_t              sts,
	output out_item_t         result,
	output logic              result_valid
);

	logic [EDGE_W-1:0] edge_mem [DEPTH];
	logic [EDGE_W-1:0] rdata_q;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [EDGE_W-1:0] wdata;

	logic [ADDR_W:0]   tcnt_q;
	logic              tv_s1;
	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  sw_q;
	logic [CNT_W-1:0]  sp_q;
	logic [CNT_W-1:0]  placed_q;

	logic [REM_W-1:0]  rem_q [MAX_NODES];
	logic [NODE_W-1:0] stk_node_q [MAX_NODES];
	logic [SLOT_W-1:0] stk_slot_q [MAX_NODES];
	logic [NODE_W-1:0] order_q [MAX_NODES];

	out_item_t res_q;
	logic      res_valid_q;

	logic              ev;
	logic [NODE_W-1:0] et;
	logic              e_hit;
	logic [NODE_W-1:0] rem_sel;
	logic [IDX_W-1:0]  ri;
	logic [REM_W-1:0]  rem_cur;
	logic [IDX_W-1:0]  top_i;
	logic [NODE_W-1:0] top_node;
	logic [SLOT_W-1:0] top_slot;
	logic              push;
	logic              in_range;

	assign ev    = rdata_q[EDGE_W-1];
	assign et    = rdata_q[NODE_W-1:0];
	assign e_hit = ev && ({1'b0, et} < n);

	assign rem_sel = cmd.sel_entry ? entry : (cmd.sweep_step ? sw_q[NODE_W-1:0] : et);
	assign ri      = rem_sel[IDX_W-1:0];
	assign rem_cur = rem_q[ri];

	assign top_i    = IDX_W'(sp_q - CNT_W'(1));
	assign top_node = stk_node_q[top_i];
	assign top_slot = stk_slot_q[top_i];

	assign push = cmd.walk_ex && e_hit && (rem_cur == REM_W'(1)) &&
		(placed_q < CNT_W'(MAX_NODES)) && (sp_q < CNT_W'(MAX_NODES));

	assign in_range = ({1'b0, item.node_index} < (NODE_W+1)'(MAX_NODES)) &&
		({1'b0, item.slot_index} < (SLOT_W+1)'(MAX_OUTPUTS));

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.clear_step) begin
			we = 1'b1;
		end else if (cmd.load && in_range) begin
			we    = 1'b1;
			waddr = ADDR_W'(item.node_index) * ADDR_W'(MAX_OUTPUTS) + ADDR_W'(item.slot_index);
			wdata = item.target_valid ? {1'b1, item.target} : '0;
		end
	end

	always_comb begin
		if (cmd.walk_rd)
			raddr = ADDR_W'(top_node) * ADDR_W'(MAX_OUTPUTS) + ADDR_W'(top_slot);
		else
			raddr = tcnt_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (we)
			edge_mem[waddr] <= wdata;
		rdata_q <= edge_mem[raddr];
	end

	assign sts.entry_bad   = ({1'b0, entry} >= n);
	assign sts.tally_done  = (tcnt_q == (ADDR_W+1)'(n) * (ADDR_W+1)'(MAX_OUTPUTS));
	assign sts.rem_nz      = (rem_cur != '0);
	assign sts.sweep_last  = (sw_q == n - CNT_W'(1));
	assign sts.sw_is_entry = (sw_q == {1'b0, entry});
	assign sts.sp_zero     = (sp_q == '0);
	assign sts.clear_last  = (clr_q == ADDR_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcnt_q      <= '0;
			tv_s1       <= 1'b0;
			clr_q       <= '0;
			sw_q        <= '0;
			sp_q        <= '0;
			placed_q    <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++)
				rem_q[i] <= '0;
		end else begin
			tv_s1       <= cmd.tally_issue;
			res_valid_q <= cmd.emit_step || cmd.emit_err;

			if (cmd.clear_step)
				clr_q <= sts.clear_last ? '0 : clr_q + ADDR_W'(1);

			if (cmd.run_init)
				tcnt_q <= '0;
			else if (cmd.tally_issue)
				tcnt_q <= tcnt_q + (ADDR_W+1)'(1);

			if (cmd.sweep_init)
				sw_q <= '0;
			else if (cmd.sweep_step || cmd.emit_step)
				sw_q <= sw_q + CNT_W'(1);

			if (cmd.run_init) begin
				for (int i = 0; i < MAX_NODES; i++)
					rem_q[i] <= '0;
			end else if (tv_s1 && e_hit) begin
				rem_q[ri] <= rem_cur + REM_W'(1);
			end else if (cmd.walk_ex && e_hit) begin
				rem_q[ri] <= rem_cur - REM_W'(1);
			end

			if (cmd.walk_init) begin
				sp_q     <= CNT_W'(1);
				placed_q <= CNT_W'(1);
			end else if (cmd.walk_rd) begin
				if ({1'b0, top_slot} + (SLOT_W+1)'(1) >= (SLOT_W+1)'(MAX_OUTPUTS))
					sp_q <= sp_q - CNT_W'(1);
			end else if (push) begin
				sp_q     <= sp_q + CNT_W'(1);
				placed_q <= placed_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			order_q[0]    <= entry;
			stk_node_q[0] <= entry;
			stk_slot_q[0] <= '0;
		end else if (cmd.walk_rd) begin
			if ({1'b0, top_slot} + (SLOT_W+1)'(1) < (SLOT_W+1)'(MAX_OUTPUTS))
				stk_slot_q[top_i] <= top_slot + SLOT_W'(1);
		end else if (push) begin
			order_q[placed_q[IDX_W-1:0]]  <= et;
			stk_node_q[sp_q[IDX_W-1:0]]   <= et;
			stk_slot_q[sp_q[IDX_W-1:0]]   <= '0;
		end

		if (cmd.emit_err) begin
			res_q.position    <= '0;
			res_q.node_id     <= '0;
			res_q.status      <= cmd.err_code;
			res_q.last_result <= 1'b1;
		end else begin
			res_q.position    <= sw_q[NODE_W-1:0];
			res_q.node_id     <= order_q[sw_q[IDX_W-1:0]];
			res_q.status      <= ST_OK;
			res_q.last_result <= sts.sweep_last;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

// File: sv/dag_topological_order_top.sv
// Topological ordering of a small directed graph.
// Input: pulse start with an edge slot on item while busy is low; one item per
// cycle is taken while loading. The item with last set starts the run.
// Configuration: cfg_valid/cfg_ready write node_count (index 0) or entry_node
// (index 1); cfg_ready is always high. Write only while busy is low.
// Run: an in-degree pass reads node_count*32 slots, one per cycle; then the
// node checks run; the depth-first walk reads each slot of each placed node
// (32 slots per placed node) with a read step and an execute step, over one
// edge memory port.
// Results appear on result with result_valid high for one cycle each, one
// per cycle, node_count (clamped to 1..32) of them, or a single error item;
// last_result marks the final one. The receiver cannot stall; results are
// never held. After every run, and after reset, the edge memory is swept
// clear at one entry per cycle, all 1024 entries, with busy high.
// Reset (arst_n low) returns node_count to 1 and entry_node to 0.
module dag_topological_order_top import dto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output out_item_t   result,
	output logic        result_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	logic [CNT_W-1:0]  node_count_q;
	logic [NODE_W-1:0] entry_node_q;
	logic [CNT_W-1:0]  n_eff;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			entry_node_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data;
				REG_ENTRY_NODE: entry_node_q <= cfg_data[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (node_count_q == '0)
			n_eff = CNT_W'(1);
		else if (node_count_q > CNT_W'(MAX_NODES))
			n_eff = CNT_W'(MAX_NODES);
		else
			n_eff = node_count_q;
	end

	dto_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (item.last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dto_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.n            (n_eff),
		.entry        (entry_node_q),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
